// ===== design/dsta_pkg.sv =====
// Shared types and codes for the dual stream timestamp aligner.
`default_nettype none
package dsta_pkg;

    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int DRIFT_W    = 8;
    localparam int TS_W       = 32;
    localparam int LEN_W      = 16;
    localparam int THRESH_W   = 16;
    localparam int LIMIT_W    = 32;
    localparam int PPB_W      = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 16;

    localparam logic [PPB_W-1:0] MAX_PAIRS = 5'd16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HELD     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REF_DROP = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MIC_DROP = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DRIFT    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_THRESH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONV_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIFT_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAIRS_BLK   = 3'd4;

    localparam int SRC_MIC = 1;

    typedef struct packed {
        logic                timeout_warn;
        logic                streaming;
        logic [DRIFT_W-1:0]  drift_run;
        logic                block_done;
        logic [SLOT_W-1:0]   pair_slot;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic              cmd;
        logic [TS_W-1:0]   capture_ts;
        logic [LEN_W-1:0]  frame_len;
        logic [TS_W-1:0]   now_ms;
    } req_t;

endpackage
`default_nettype wire

// ===== design/dual_stream_timestamp_aligner.sv =====
// Top level: timestamp pairing of reference and microphone frame descriptors.
`default_nettype none
// Takes one frame descriptor request per cycle and returns one result per request.
// A request sits in an input register, is resolved against the two timestamp
// slots by a single compare-and-update step, and lands in the result register,
// so throughput is one request per cycle as long as m_tready stays high; a
// stalled result holds the input register, and the slot state, counters and
// convergence timer change only as a result is loaded.
// s_tuser[0] = cmd (0 reference, 1 microphone). Configuration writes take effect
// on the next cycle and are meant to be issued while the block is idle.
module dual_stream_timestamp_aligner #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [dsta_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [dsta_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input requests
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: capture_ts[31:0], frame_len[47:32], now_ms[79:48]
    input  wire logic [dsta_pkg::S_DATA_W-1:0]     s_tdata,
    // tuser: cmd[0]
    input  wire logic [0:0]                        s_tuser,
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: pair_slot[3:0], block_done[4], drift_run[12:5], streaming[13],
    //        timeout_warn[14], zero[15]
    output logic [dsta_pkg::M_DATA_W-1:0]          m_tdata,
    // tuser: status[2:0]
    output logic [dsta_pkg::STATUS_W-1:0]          m_tuser
);
    import dsta_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    typedef logic [TIME_BITS-1:0] tstamp_t;

    // configuration registers
    logic [THRESH_W-1:0] sync_thresh_reg;
    logic [LIMIT_W-1:0]  conv_limit_reg;
    logic [DRIFT_W-1:0]  drift_limit_reg;
    logic [LEN_W-1:0]    frame_len_reg;
    logic [PPB_W-1:0]    pairs_blk_reg;

    // block state
    logic                mode_streaming_reg, mode_streaming_next;
    logic                ref_held_reg, ref_held_next;
    logic                mic_held_reg, mic_held_next;
    tstamp_t             ref_time_reg, ref_time_next;
    tstamp_t             mic_time_reg, mic_time_next;
    logic                ref_bad_reg, ref_bad_next;
    logic                mic_bad_reg, mic_bad_next;
    logic [SLOT_W-1:0]   pair_count_reg, pair_count_next;
    logic [DRIFT_W-1:0]  drift_count_reg, drift_count_next;
    tstamp_t             epoch_reg, epoch_next;
    logic                warned_reg, warned_next;

    // pipeline registers
    logic                in_valid_reg;
    req_t                in_req_reg;
    logic                out_valid_reg;
    res_t                res_reg, res_next;

    logic                advance;
    logic                fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {1'b0, res_reg.timeout_warn, res_reg.streaming, res_reg.drift_run,
                       res_reg.block_done, res_reg.pair_slot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_thresh_reg <= THRESH_W'(5);
            conv_limit_reg  <= LIMIT_W'(1000);
            drift_limit_reg <= DRIFT_W'(3);
            frame_len_reg   <= LEN_W'(1024);
            pairs_blk_reg   <= PPB_W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC_THRESH: sync_thresh_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_CONV_LIMIT:  conv_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_DRIFT_LIMIT: drift_limit_reg <= cfg_wdata[DRIFT_W-1:0];
                CFG_FRAME_LEN:   frame_len_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_PAIRS_BLK:   pairs_blk_reg   <= cfg_wdata[PPB_W-1:0];
                default: ;
            endcase
        end
    end

    // resolve one request
    tstamp_t            req_ts;
    tstamp_t            req_now;
    tstamp_t            gap;
    tstamp_t            elapsed;
    logic               busy;
    logic               is_mic;
    logic               len_bad;
    logic               gap_over;
    logic               warn_due;
    logic [PPB_W-1:0]   eff_pairs;
    logic [PPB_W-1:0]   next_count;
    logic [DRIFT_W-1:0] drift_inc;
    logic               accept;
    logic               do_resync;

    always_comb begin
        req_ts   = TIME_BITS'(in_req_reg.capture_ts);
        req_now  = TIME_BITS'(in_req_reg.now_ms);
        is_mic   = (in_req_reg.cmd == 1'(SRC_MIC));
        busy     = is_mic ? mic_held_reg : ref_held_reg;
        len_bad  = (in_req_reg.frame_len != frame_len_reg);
        elapsed  = req_now - epoch_reg;
        warn_due = !warned_reg && (CMP_BITS'(elapsed) > CMP_BITS'(conv_limit_reg));

        priority if (pairs_blk_reg == '0) begin
            eff_pairs = PPB_W'(1);
        end else if (pairs_blk_reg > MAX_PAIRS) begin
            eff_pairs = MAX_PAIRS;
        end else begin
            eff_pairs = pairs_blk_reg;
        end
        next_count = {1'b0, pair_count_reg} + PPB_W'(1);
        drift_inc  = drift_count_reg + DRIFT_W'(1);

        mode_streaming_next = mode_streaming_reg;
        ref_held_next       = ref_held_reg;
        mic_held_next       = mic_held_reg;
        ref_time_next       = ref_time_reg;
        mic_time_next       = mic_time_reg;
        ref_bad_next        = ref_bad_reg;
        mic_bad_next        = mic_bad_reg;
        pair_count_next     = pair_count_reg;
        drift_count_next    = drift_count_reg;
        epoch_next          = epoch_reg;
        warned_next         = warned_reg;
        accept              = 1'b0;
        do_resync           = 1'b0;

        res_next.status       = ST_HELD;
        res_next.pair_slot    = '0;
        res_next.block_done   = 1'b0;
        res_next.timeout_warn = 1'b0;

        if (!busy) begin
            if (is_mic) begin
                mic_held_next = 1'b1;
                mic_time_next = req_ts;
                mic_bad_next  = len_bad;
            end else begin
                ref_held_next = 1'b1;
                ref_time_next = req_ts;
                ref_bad_next  = len_bad;
            end
        end

        gap      = (ref_time_next > mic_time_next) ? (ref_time_next - mic_time_next)
                                                   : (mic_time_next - ref_time_next);
        gap_over = CMP_BITS'(gap) > CMP_BITS'(sync_thresh_reg);

        if (busy) begin
            res_next.status = ST_REFUSED;
        end else if (ref_held_next && mic_held_next) begin
            priority if (ref_bad_next || mic_bad_next) begin
                ref_held_next   = 1'b0;
                mic_held_next   = 1'b0;
                do_resync       = 1'b1;
                res_next.status = ST_BAD_LEN;
            end else if (gap_over) begin
                if (!mode_streaming_reg) begin
                    // syncing: keep the later frame
                    if (ref_time_next > mic_time_next) begin
                        mic_held_next   = 1'b0;
                        res_next.status = ST_MIC_DROP;
                    end else begin
                        ref_held_next   = 1'b0;
                        res_next.status = ST_REF_DROP;
                    end
                    do_resync = 1'b1;
                end else if (drift_inc < drift_limit_reg) begin
                    drift_count_next = drift_inc;
                    accept           = 1'b1;
                end else begin
                    ref_held_next   = 1'b0;
                    mic_held_next   = 1'b0;
                    do_resync       = 1'b1;
                    res_next.status = ST_DRIFT;
                end
            end else begin
                drift_count_next    = '0;
                mode_streaming_next = 1'b1;
                accept              = 1'b1;
            end
        end

        if (do_resync) begin
            mode_streaming_next = 1'b0;
            pair_count_next     = '0;
            drift_count_next    = '0;
            if (warn_due) begin
                warned_next           = 1'b1;
                res_next.timeout_warn = 1'b1;
            end
        end

        if (accept) begin
            res_next.status    = ST_ACCEPTED;
            res_next.pair_slot = pair_count_reg;
            ref_held_next      = 1'b0;
            mic_held_next      = 1'b0;
            if (next_count >= eff_pairs) begin
                pair_count_next     = '0;
                res_next.block_done = 1'b1;
                epoch_next          = req_now;
                warned_next         = 1'b0;
            end else begin
                pair_count_next = next_count[SLOT_W-1:0];
            end
        end

        res_next.drift_run = drift_count_next;
        res_next.streaming = mode_streaming_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_streaming_reg <= 1'b0;
            ref_held_reg       <= 1'b0;
            mic_held_reg       <= 1'b0;
            pair_count_reg     <= '0;
            drift_count_reg    <= '0;
            epoch_reg          <= '0;
            warned_reg         <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                mode_streaming_reg <= mode_streaming_next;
                ref_held_reg       <= ref_held_next;
                mic_held_reg       <= mic_held_next;
                pair_count_reg     <= pair_count_next;
                drift_count_reg    <= drift_count_next;
                epoch_reg          <= epoch_next;
                warned_reg         <= warned_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg.cmd        <= s_tuser[0];
            in_req_reg.capture_ts <= s_tdata[TS_W-1:0];
            in_req_reg.frame_len  <= s_tdata[TS_W+LEN_W-1:TS_W];
            in_req_reg.now_ms     <= s_tdata[S_DATA_W-1:TS_W+LEN_W];
        end
        if (fire) begin
            res_reg       <= res_next;
            ref_time_reg  <= ref_time_next;
            mic_time_reg  <= mic_time_next;
            ref_bad_reg   <= ref_bad_next;
            mic_bad_reg   <= mic_bad_next;
        end
    end

    // both slots full is always resolved within the same request
    a_no_both_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ref_held_reg && mic_held_reg))
        else $error("both slots held after resolution");

    a_drift_needs_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (drift_count_reg != '0) |-> mode_streaming_reg)
        else $error("drift count nonzero while syncing");

    a_slot_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_reg.status != ST_ACCEPTED)) |->
            ((res_reg.pair_slot == '0) && !res_reg.block_done))
        else $error("pair slot or block done on a non-accepted result");

    a_warn_on_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.timeout_warn) |->
            ((res_reg.status == ST_BAD_LEN) || (res_reg.status == ST_REF_DROP) ||
             (res_reg.status == ST_MIC_DROP) || (res_reg.status == ST_DRIFT)))
        else $error("timeout warning without a resync");

    a_stall_holds_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("pending request lost during output stall");

endmodule
`default_nettype wire

// ===== verif/dual_stream_timestamp_aligner_tb.sv =====
// Testbench for the dual stream timestamp aligner: directed table, random pairs, scoreboard.
module dual_stream_timestamp_aligner_tb;
    import dsta_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYC        = 150;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int DIR_N           = 21;

    localparam logic CMD_REF = 1'b0;
    localparam logic CMD_MIC = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TS_W-1:0]   ts;
        logic [LEN_W-1:0]  len;
        logic [TS_W-1:0]   now;
        logic              typed;   // res below is the expected result
        res_t              res;
    } dir_row_t;

    // register defaults: threshold 5, limit 1000, drift 3, length 1024, two pairs per block
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{CMD_REF, 32'd100,        16'd1024,   32'd10, 1'b1, '{status: ST_HELD, default: '0}},
        '{CMD_REF, 32'd200,        16'd1024,   32'd11, 1'b1,
          '{status: ST_REFUSED, default: '0}},
        '{CMD_MIC, 32'd103,        16'd1024,   32'd12, 1'b1,
          '{status: ST_ACCEPTED, streaming: 1'b1, default: '0}},
        '{CMD_MIC, 32'hFFFF_FFFF,  16'd1024,   32'd13,   1'b0, '0},
        '{CMD_REF, 32'hFFFF_FFFA,  16'd1024,   32'd14,   1'b0, '0},
        // drifting pairs while streaming, third one hits the drift limit
        '{CMD_REF, 32'd1000,       16'd1024,   32'd20,   1'b0, '0},
        '{CMD_MIC, 32'd1010,       16'd1024,   32'd21,   1'b0, '0},
        '{CMD_MIC, 32'd2000,       16'd1024,   32'd22,   1'b0, '0},
        '{CMD_REF, 32'd2020,       16'd1024,   32'd23,   1'b0, '0},
        '{CMD_REF, 32'd3000,       16'd1024,   32'd4990, 1'b0, '0},
        '{CMD_MIC, 32'd3050,       16'd1024,   32'd5000, 1'b0, '0},
        // syncing: earlier frame of a wide gap is dropped
        '{CMD_REF, 32'd500,        16'd1024,   32'd5001, 1'b0, '0},
        '{CMD_MIC, 32'd0,          16'd1024,   32'd5002, 1'b0, '0},
        '{CMD_MIC, 32'd600,        16'd1024,   32'd5003, 1'b0, '0},
        // bad lengths on either side
        '{CMD_REF, 32'd600,        16'd0,      32'd0,    1'b0, '0},
        '{CMD_MIC, 32'd7,          16'hFFFF,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_REF, 32'd7,          16'd1024,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_REF, 32'd0,          16'd1024,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_MIC, 32'd0,          16'd1024,   32'd0,    1'b0, '0},
        '{CMD_MIC, 32'h8000_0000,  16'h8000,   32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_REF, 32'h7FFF_FFFF,  16'd1024,   32'h8000_0000, 1'b0, '0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // register copies
    logic [THRESH_W-1:0] sync_thr      = 16'd5;
    logic [LIMIT_W-1:0]  conv_lim      = 32'd1000;
    logic [DRIFT_W-1:0]  drift_lim     = 8'd3;
    logic [LEN_W-1:0]    frame_len_req = 16'd1024;
    logic [PPB_W-1:0]    blk_pairs     = 5'd2;

    // aligner state
    logic                streaming_q = 1'b0;
    logic                ref_busy    = 1'b0;
    logic                mic_busy    = 1'b0;
    logic [TS_W-1:0]     ref_ts      = '0;
    logic [TS_W-1:0]     mic_ts      = '0;
    logic                ref_bad     = 1'b0;
    logic                mic_bad     = 1'b0;
    logic [SLOT_W-1:0]   pair_idx    = '0;
    logic [DRIFT_W-1:0]  drift_cnt   = '0;
    logic [TS_W-1:0]     epoch       = '0;
    logic                warned_q    = 1'b0;

    res_t expected_results [$];
    int   fail_cnt   = 0;
    int   cycle_cnt  = 0;
    int   send_idle  = 0;
    int   recv_stall = 0;
    int   hold_reqs  = 0;

    always #1 aclk = ~aclk;

    dual_stream_timestamp_aligner uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic logic resync_align(logic [TS_W-1:0] now);
        logic [TS_W-1:0] elapsed;
        elapsed     = now - epoch;
        streaming_q = 1'b0;
        pair_idx    = '0;
        drift_cnt   = '0;
        if (!warned_q && elapsed > conv_lim) begin
            warned_q = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic res_t align_frame(logic src, logic [TS_W-1:0] ts,
                                         logic [LEN_W-1:0] len, logic [TS_W-1:0] now);
        res_t            r;
        logic [TS_W-1:0] gap;
        logic            accept;
        logic [PPB_W-1:0] eff;
        r      = '0;
        accept = 1'b0;
        if ((src == CMD_REF && ref_busy) || (src == CMD_MIC && mic_busy)) begin
            r.status = ST_REFUSED;
        end else begin
            r.status = ST_HELD;
            if (src == CMD_REF) begin
                ref_busy = 1'b1;
                ref_ts   = ts;
                ref_bad  = (len != frame_len_req);
            end else begin
                mic_busy = 1'b1;
                mic_ts   = ts;
                mic_bad  = (len != frame_len_req);
            end
            if (ref_busy && mic_busy) begin
                gap = (ref_ts > mic_ts) ? ref_ts - mic_ts : mic_ts - ref_ts;
                if (ref_bad || mic_bad) begin
                    ref_busy = 1'b0;
                    mic_busy = 1'b0;
                    r.timeout_warn = resync_align(now);
                    r.status = ST_BAD_LEN;
                end else if (gap > {16'd0, sync_thr}) begin
                    if (!streaming_q) begin
                        // keep the later frame
                        if (ref_ts > mic_ts) begin
                            mic_busy = 1'b0;
                            r.status = ST_MIC_DROP;
                        end else begin
                            ref_busy = 1'b0;
                            r.status = ST_REF_DROP;
                        end
                        r.timeout_warn = resync_align(now);
                    end else begin
                        drift_cnt = drift_cnt + 8'd1;
                        if (drift_cnt < drift_lim) begin
                            accept = 1'b1;
                        end else begin
                            ref_busy = 1'b0;
                            mic_busy = 1'b0;
                            r.timeout_warn = resync_align(now);
                            r.status = ST_DRIFT;
                        end
                    end
                end else begin
                    drift_cnt   = '0;
                    streaming_q = 1'b1;
                    accept      = 1'b1;
                end
                if (accept) begin
                    eff = (blk_pairs == 0) ? 5'd1 : (blk_pairs > MAX_PAIRS) ? MAX_PAIRS : blk_pairs;
                    r.status    = ST_ACCEPTED;
                    r.pair_slot = pair_idx;
                    ref_busy    = 1'b0;
                    mic_busy    = 1'b0;
                    if ({1'b0, pair_idx} + 5'd1 >= eff) begin
                        pair_idx     = '0;
                        r.block_done = 1'b1;
                        epoch        = now;
                        warned_q     = 1'b0;
                    end else begin
                        pair_idx = pair_idx + 4'd1;
                    end
                end
            end
        end
        r.drift_run = drift_cnt;
        r.streaming = streaming_q;
        return r;
    endfunction

    // Offer one request; predict its result once it is taken.
    task automatic send_frame(logic src, logic [TS_W-1:0] ts, logic [LEN_W-1:0] len,
                              logic [TS_W-1:0] now, logic typed = 1'b0, res_t typed_res = '0);
        res_t r;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= src;
        s_tdata  <= {now, len, ts};
        do @(posedge aclk); while (!s_tready);
        r = align_frame(src, ts, len, now);
        expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            CFG_SYNC_THRESH: sync_thr      = data[THRESH_W-1:0];
            CFG_CONV_LIMIT:  conv_lim      = data[LIMIT_W-1:0];
            CFG_DRIFT_LIMIT: drift_lim     = data[DRIFT_W-1:0];
            CFG_FRAME_LEN:   frame_len_req = data[LEN_W-1:0];
            CFG_PAIRS_BLK:   blk_pairs     = data[PPB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int thr, int unsigned lim, int dl, int flen, int ppb);
        cfg_write(CFG_SYNC_THRESH, thr);
        cfg_write(CFG_CONV_LIMIT, lim);
        cfg_write(CFG_DRIFT_LIMIT, dl);
        cfg_write(CFG_FRAME_LEN, flen);
        cfg_write(CFG_PAIRS_BLK, ppb);
        cfg_wr_en <= 1'b0;
    endtask

    // result receiver: random stalls plus long hold-offs on request
    initial begin : rx_ready
        int left;
        int served;
        left   = 0;
        served = 0;
        forever begin
            @(posedge aclk);
            if (served != hold_reqs) begin
                served = hold_reqs;
                left   = HOLD_CYC;
            end
            if (left > 0) begin
                left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge aclk) begin
        res_t got;
        res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = m_tuser;
            got.pair_slot    = m_tdata[3:0];
            got.block_done   = m_tdata[4];
            got.drift_run    = m_tdata[12:5];
            got.streaming    = m_tdata[13];
            got.timeout_warn = m_tdata[14];
            if (expected_results.size() == 0) begin
                if (fail_cnt < 10)
                    $display("cycle %0d: result with nothing outstanding", cycle_cnt);
                fail_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    if (fail_cnt < 10) begin
                        $display("cycle %0d: exp st=%0d slot=%0d done=%0d drift=%0d str=%0d warn=%0d",
                                 cycle_cnt, exp_r.status, exp_r.pair_slot, exp_r.block_done,
                                 exp_r.drift_run, exp_r.streaming, exp_r.timeout_warn);
                        $display("    got st=%0d slot=%0d done=%0d drift=%0d str=%0d warn=%0d",
                                 got.status, got.pair_slot, got.block_done, got.drift_run,
                                 got.streaming, got.timeout_warn);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int              n;
        int              pick;
        logic            first_src;
        logic            held_once;
        logic            drained_once;
        logic [TS_W-1:0] base;
        logic [TS_W-1:0] other;
        logic [TS_W-1:0] delta;
        logic [TS_W-1:0] cap_ms;
        logic [TS_W-1:0] wall;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
        cap_ms       = '0;
        wall         = '0;
        held_once    = 1'b0;
        drained_once = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++)
            send_frame(DIR_TAB[i].cmd, DIR_TAB[i].ts, DIR_TAB[i].len, DIR_TAB[i].now,
                       DIR_TAB[i].typed, DIR_TAB[i].res);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle = 0;  recv_stall = 0;
                    apply_config(5, 1000, 3, 1024, 3);
                end
                1: begin
                    send_idle = 80; recv_stall = 0;
                    apply_config(0, 0, 1, 1, 1);
                end
                2: begin
                    send_idle = 0;  recv_stall = 80;
                    apply_config(65535, 32'hFFFF_FFFF, 255, 65535, 16);
                end
                default: begin
                    send_idle = 18; recv_stall = 18;
                    apply_config($urandom_range(1, 50), $urandom_range(10, 5000),
                                 $urandom_range(2, 8), $urandom_range(1, 65535),
                                 $urandom_range(2, 16));
                end
            endcase
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // sender keeps pushing through a long receiver hold-off
                if (phase == 0 && n >= 60 && !held_once) begin
                    hold_reqs++;
                    held_once = 1'b1;
                end
                if (phase == 0 && n >= 120 && !drained_once) begin
                    drain_results();
                    drained_once = 1'b1;
                end
                wall = wall + $urandom_range(0, 200);
                if ($urandom_range(99) < 3) wall = $urandom;
                if ($urandom_range(99) < 85) begin
                    // well-formed pair, gap mostly near the threshold
                    if ($urandom_range(9) == 0) begin
                        base = $urandom;
                    end else begin
                        cap_ms = cap_ms + $urandom_range(1, 40);
                        base   = cap_ms;
                    end
                    pick = $urandom_range(9);
                    if (pick < 5)       delta = $urandom_range(0, sync_thr);
                    else if (pick == 5) delta = sync_thr;
                    else if (pick == 6) delta = sync_thr + 1;
                    else if (pick < 9)  delta = sync_thr + 1 + $urandom_range(0, 30);
                    else                delta = $urandom;
                    other     = $urandom_range(1) ? base + delta : base - delta;
                    first_src = 1'($urandom_range(1));
                    len_a = ($urandom_range(99) < 92) ? frame_len_req
                                                      : LEN_W'($urandom_range(65535));
                    len_b = ($urandom_range(99) < 92) ? frame_len_req
                                                      : LEN_W'($urandom_range(65535));
                    send_frame(first_src, base, len_a, wall);
                    wall = wall + $urandom_range(0, 50);
                    send_frame(~first_src, other, len_b, wall);
                    n += 2;
                end else begin
                    len_a = $urandom_range(1) ? frame_len_req : LEN_W'($urandom_range(65535));
                    send_frame(1'($urandom_range(1)), $urandom, len_a, wall);
                    n++;
                end
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
